@@ hw/rtl/dbcs_pkg.sv @@
// Shared types, constants and the digit-to-segment map of the debounced counter.
package dbcs_pkg;

  localparam int NUM_DIGITS_DEF = 4;
  localparam int COUNT_DIGITS   = 4;
  localparam int COUNT_MAX      = 9999;

  localparam logic [7:0] HOLD_RESET = 8'd5;
  localparam logic [7:0] SCAN_RESET = 8'd2;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_HOLD = 1'b0;
  localparam logic REG_SCAN = 1'b1;

  // digit positions: thousands, hundreds, units, tens
  localparam logic [1:0] POS_THOUSANDS = 2'd0;
  localparam logic [1:0] POS_HUNDREDS  = 2'd1;
  localparam logic [1:0] POS_UNITS     = 2'd2;
  localparam logic [1:0] POS_TENS      = 2'd3;

  typedef struct packed {
    logic [7:0] hold_ticks;
    logic [7:0] scan_ticks;
  } dbcs_cfg_t;

  typedef struct packed {
    logic [3:0]  digit_enable;
    logic [6:0]  segments;
    logic [13:0] count_value;
    logic        counted;
  } dbcs_result_t;

  function automatic logic [6:0] seg_map(input logic [3:0] digit);
    logic [6:0] segs;
    unique case (digit)
      4'd0:    segs = 7'b1110111;
      4'd1:    segs = 7'b0010001;
      4'd2:    segs = 7'b1101101;
      4'd3:    segs = 7'b0111101;
      4'd4:    segs = 7'b0011011;
      4'd5:    segs = 7'b0111110;
      4'd6:    segs = 7'b1111110;
      4'd7:    segs = 7'b0010101;
      4'd8:    segs = 7'b1111111;
      4'd9:    segs = 7'b0011111;
      default: segs = 7'b0000000;
    endcase
    return segs;
  endfunction

endpackage

@@ hw/rtl/debounced_bcd_counter_seven_segment.sv @@
// Top level of the debounced four-digit decimal counter with multiplexed display.
//
//   channel | direction | payload                                      | handshake
//   in      | input     | in_pin_level                                 | in_valid / in_stall
//   out     | output    | out_digit_enable, out_segments, out_count_value, out_counted
//           |           |                                              | out_valid / out_stall
//   cfg     | APB       | hold_ticks @0x0, scan_ticks @0x4             | psel / penable / pready
//
// One request per clock while in_stall is low; each result is registered in the output
// register, or in the skid stage while the result side stalls. The skid stage takes one
// request while the output register is held, and in_stall rises only when both
// the output register and the skid stage are full.
// Reset clears the count, the debounce state and the scan, and loads hold 5, scan 2.
module debounced_bcd_counter_seven_segment #(
  parameter int NUM_DIGITS = dbcs_pkg::NUM_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_pin_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  out_digit_enable,
  output logic [6:0]                  out_segments,
  output logic [13:0]                 out_count_value,
  output logic                        out_counted,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbcs_pkg::ADDR_W-1:0] paddr,
  input  logic [dbcs_pkg::DATA_W-1:0] pwdata,
  output logic [dbcs_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  dbcs_pkg::dbcs_cfg_t    cfg;
  dbcs_pkg::dbcs_result_t result;
  dbcs_pkg::dbcs_result_t out_data;
  logic                   accept;
  logic                   full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  dbcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dbcs_core #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .pin_level (in_pin_level),
    .cfg       (cfg),
    .result    (result)
  );

  dbcs_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .result    (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_digit_enable = out_data.digit_enable;
  assign out_segments     = out_data.segments;
  assign out_count_value  = out_data.count_value;
  assign out_counted      = out_data.counted;

endmodule

@@ hw/rtl/dbcs_cfg.sv @@
// APB register file holding the hold and scan tick counts.
module dbcs_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dbcs_pkg::ADDR_W-1:0]   paddr,
  input  logic [dbcs_pkg::DATA_W-1:0]   pwdata,
  output logic [dbcs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output dbcs_pkg::dbcs_cfg_t           cfg
);

  logic [7:0] hold_r, hold_nxt;
  logic [7:0] scan_r, scan_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    hold_nxt = hold_r;
    scan_nxt = scan_r;
    if (wr_en) begin
      unique case (paddr[2])
        dbcs_pkg::REG_HOLD: hold_nxt = pwdata[7:0];
        dbcs_pkg::REG_SCAN: scan_nxt = pwdata[7:0];
        default:            hold_nxt = hold_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= dbcs_pkg::HOLD_RESET;
      scan_r <= dbcs_pkg::SCAN_RESET;
    end else begin
      hold_r <= hold_nxt;
      scan_r <= scan_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      dbcs_pkg::REG_HOLD: prdata[7:0] = hold_r;
      dbcs_pkg::REG_SCAN: prdata[7:0] = scan_r;
      default:            prdata      = '0;
    endcase
  end

  assign cfg.hold_ticks = hold_r;
  assign cfg.scan_ticks = scan_r;

endmodule

@@ hw/rtl/dbcs_core.sv @@
// Debounce, decimal count and display scan state, one update per accepted request.
module dbcs_core #(
  parameter int NUM_DIGITS = dbcs_pkg::NUM_DIGITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic                   pin_level,
  input  dbcs_pkg::dbcs_cfg_t    cfg,
  output dbcs_pkg::dbcs_result_t result
);

  localparam int PosW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [PosW:0] PosLast = (PosW + 1)'(NUM_DIGITS - 1);

  logic [3:0]      digits_r   [dbcs_pkg::COUNT_DIGITS];
  logic [3:0]      digits_nxt [dbcs_pkg::COUNT_DIGITS];
  logic [13:0]     count_r, count_nxt;
  logic            prev_r, prev_nxt;
  logic            qual_r, qual_nxt;
  logic [7:0]      low_r, low_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [7:0]      timer_r, timer_nxt, timer_inc;
  logic            hit;
  logic            c_units, c_tens, c_hund;
  logic [3:0]      shown;
  logic [3:0]      enable;

  always_comb begin
    qual_nxt = qual_r;
    low_nxt  = low_r;
    if (qual_r) begin
      if (pin_level) begin
        qual_nxt = 1'b0;
      end else if (low_r != 8'hFF) begin
        low_nxt = low_r + 8'd1;
      end
    end else if (!pin_level && prev_r) begin
      qual_nxt = 1'b1;
      low_nxt  = 8'd1;
    end
    hit = qual_nxt && (low_nxt >= cfg.hold_ticks);
    if (hit) begin
      qual_nxt = 1'b0;
    end
    prev_nxt = pin_level;
  end

  always_comb begin
    for (int i = 0; i < dbcs_pkg::COUNT_DIGITS; i++) begin
      digits_nxt[i] = digits_r[i];
    end
    c_units = digits_r[dbcs_pkg::POS_UNITS] >= 4'd9;
    c_tens  = c_units && (digits_r[dbcs_pkg::POS_TENS] >= 4'd9);
    c_hund  = c_tens && (digits_r[dbcs_pkg::POS_HUNDREDS] >= 4'd9);
    count_nxt = count_r;
    if (hit) begin
      digits_nxt[dbcs_pkg::POS_UNITS] = c_units ? 4'd0 : digits_r[dbcs_pkg::POS_UNITS] + 4'd1;
      if (c_units) begin
        digits_nxt[dbcs_pkg::POS_TENS] = c_tens ? 4'd0 : digits_r[dbcs_pkg::POS_TENS] + 4'd1;
      end
      if (c_tens) begin
        digits_nxt[dbcs_pkg::POS_HUNDREDS] =
          c_hund ? 4'd0 : digits_r[dbcs_pkg::POS_HUNDREDS] + 4'd1;
      end
      if (c_hund) begin
        digits_nxt[dbcs_pkg::POS_THOUSANDS] = (digits_r[dbcs_pkg::POS_THOUSANDS] >= 4'd9) ?
          4'd0 : digits_r[dbcs_pkg::POS_THOUSANDS] + 4'd1;
      end
      count_nxt = (count_r >= 14'(dbcs_pkg::COUNT_MAX)) ? 14'd0 : count_r + 14'd1;
    end
  end

  // show the position in force with the updated digits
  always_comb begin
    shown  = 4'd0;
    enable = 4'd0;
    for (int i = 0; i < dbcs_pkg::COUNT_DIGITS; i++) begin
      if ({1'b0, pos_r} == (PosW + 1)'(i)) begin
        shown     = digits_nxt[i];
        enable[i] = 1'b1;
      end
    end
  end

  assign result.digit_enable = enable;
  assign result.segments     = (enable != 4'd0) ? dbcs_pkg::seg_map(shown) : 7'd0;
  assign result.count_value  = count_nxt;
  assign result.counted      = hit;

  always_comb begin
    timer_inc = timer_r + 8'd1;
    timer_nxt = timer_inc;
    pos_nxt   = pos_r;
    if (timer_inc >= cfg.scan_ticks) begin
      timer_nxt = 8'd0;
      pos_nxt   = ({1'b0, pos_r} >= PosLast) ? '0 : pos_r + PosW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dbcs_pkg::COUNT_DIGITS; i++) begin
        digits_r[i] <= 4'd0;
      end
      count_r <= 14'd0;
      prev_r  <= 1'b1;
      qual_r  <= 1'b0;
      low_r   <= 8'd0;
      pos_r   <= '0;
      timer_r <= 8'd0;
    end else if (accept) begin
      for (int i = 0; i < dbcs_pkg::COUNT_DIGITS; i++) begin
        digits_r[i] <= digits_nxt[i];
      end
      count_r <= count_nxt;
      prev_r  <= prev_nxt;
      qual_r  <= qual_nxt;
      low_r   <= low_nxt;
      pos_r   <= pos_nxt;
      timer_r <= timer_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 14'(dbcs_pkg::COUNT_MAX))
    else $error("count out of decimal range");
  a_qual_low: assert property (@(posedge clk) disable iff (!rst_n)
    qual_r |-> (low_r != 8'd0))
    else $error("qualifying with zero low time");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pos_r} <= PosLast)
    else $error("scan position beyond last digit");
`endif

endmodule

@@ hw/rtl/dbcs_skid.sv @@
// Output register with a skid stage between the core and the result channel.
module dbcs_skid (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  dbcs_pkg::dbcs_result_t result,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output dbcs_pkg::dbcs_result_t out_data
);

  logic                   out_valid_r, out_valid_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  dbcs_pkg::dbcs_result_t out_r, out_nxt;
  dbcs_pkg::dbcs_result_t skid_r, skid_nxt;
  logic                   take;

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = result;
        out_valid_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt       = result;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a request while output is empty");
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !accept)
    else $error("request accepted with skid full");
`endif

endmodule
